>>> design/pqrr_pkg.sv
// ----------------------------------------------------------------------------
// pqrr_pkg
// shared constants and controller/datapath signal groups of the panel queue
// ----------------------------------------------------------------------------
package pqrr_pkg;

  // default sizing
  localparam int FIFO_DEPTH_DEF  = 64;
  localparam int ROW_COUNT_DEF   = 6;
  localparam int DRAIN_BATCH_DEF = 16;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int PEND_W   = 7;
  localparam int STAT_W   = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // register map
  localparam logic [CFG_AW-1:0] REG_FIRST_ROW = 3'h0;
  localparam logic [BYTE_W-1:0] FIRST_ROW_RST = 8'd32;

  // input operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic push_exec;
    logic drain_start;
    logic rd_issue;
    logic row_step;
    logic sel_mem;
    logic sel_row;
  } pqrr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pops_zero;
    logic recov;
    logic row_last;
    logic plan_pops_zero;
    logic plan_recover;
  } pqrr_stat_t;

endpackage

>>> design/pqrr_if.sv
// ----------------------------------------------------------------------------
// pqrr_if
// valid/ready channels carrying queue requests and queue results
// ----------------------------------------------------------------------------
interface pqrr_in_if;
  import pqrr_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] command_byte;
  logic [BYTE_W-1:0] argument_byte;
  logic [BYTE_W-1:0] max_packets;

  modport source (output valid, cmd, command_byte, argument_byte, max_packets,
                  input ready);
  modport sink   (input valid, cmd, command_byte, argument_byte, max_packets,
                  output ready);
endinterface

interface pqrr_out_if;
  import pqrr_pkg::*;
  logic              valid;
  logic              ready;
  logic              packet_valid;
  logic [BYTE_W-1:0] packet_command;
  logic [BYTE_W-1:0] packet_argument;
  logic              last;
  logic              accepted;
  logic [PEND_W-1:0] pending_count;
  logic [STAT_W-1:0] overflow_count;
  logic [STAT_W-1:0] rejected_count;
  logic [STAT_W-1:0] dropped_pulse_count;
  logic [STAT_W-1:0] coalesced_row_count;
  logic [STAT_W-1:0] recovered_row_count;
  logic              recovery_pending;

  modport source (output valid, packet_valid, packet_command, packet_argument, last,
                  accepted, pending_count, overflow_count, rejected_count,
                  dropped_pulse_count, coalesced_row_count, recovered_row_count,
                  recovery_pending,
                  input ready);
  modport sink   (input valid, packet_valid, packet_command, packet_argument, last,
                  accepted, pending_count, overflow_count, rejected_count,
                  dropped_pulse_count, coalesced_row_count, recovered_row_count,
                  recovery_pending,
                  output ready);
endinterface

>>> design/panel_queue_with_row_recovery_unit.sv
// ----------------------------------------------------------------------------
// panel_queue_with_row_recovery_unit
// bounded command/argument queue with row snapshot replay after overflow
// ----------------------------------------------------------------------------
// push: result valid the cycle after acceptance
// drain: each fifo packet takes a registered store read, then the result;
//   each replayed row is one result, and an empty drain gives a single result
// one request at a time; the next is taken the cycle after the last result
// reset: synchronous active-low rst_n clears pointers, counters, snapshots
//   and the replay flag; first_row_command returns to 32
module panel_queue_with_row_recovery_unit #(
  parameter int FIFO_DEPTH  = pqrr_pkg::FIFO_DEPTH_DEF,
  parameter int ROW_COUNT   = pqrr_pkg::ROW_COUNT_DEF,
  parameter int DRAIN_BATCH = pqrr_pkg::DRAIN_BATCH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pqrr_in_if.sink                     in_ch,
  pqrr_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pqrr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pqrr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pqrr_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import pqrr_pkg::*;

  pqrr_cmd_t         cmd;
  pqrr_stat_t        stat;
  logic [BYTE_W-1:0] first_row_r;
  logic              cfg_wr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= FIRST_ROW_RST;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_FIRST_ROW[CFG_AW-1:2])) begin
      first_row_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_FIRST_ROW[CFG_AW-1:2]) ?
                      CFG_DW'(first_row_r) : '0;

  // sequencer
  pqrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  pqrr_dp #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .ROW_COUNT   (ROW_COUNT),
    .DRAIN_BATCH (DRAIN_BATCH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .stat                    (stat),
    .first_row               (first_row_r),
    .in_command_byte         (in_ch.command_byte),
    .in_argument_byte        (in_ch.argument_byte),
    .in_max_packets          (in_ch.max_packets),
    .out_packet_valid        (out_ch.packet_valid),
    .out_packet_command      (out_ch.packet_command),
    .out_packet_argument     (out_ch.packet_argument),
    .out_accepted            (out_ch.accepted),
    .out_pending_count       (out_ch.pending_count),
    .out_overflow_count      (out_ch.overflow_count),
    .out_rejected_count      (out_ch.rejected_count),
    .out_dropped_pulse_count (out_ch.dropped_pulse_count),
    .out_coalesced_row_count (out_ch.coalesced_row_count),
    .out_recovered_row_count (out_ch.recovered_row_count),
    .out_recovery_pending    (out_ch.recovery_pending)
  );

endmodule

>>> design/pqrr_ctrl.sv
// ----------------------------------------------------------------------------
// pqrr_ctrl
// sequencer for push, fifo drain, row replay and result handshake
// ----------------------------------------------------------------------------
module pqrr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_last,
  input  pqrr_pkg::pqrr_stat_t stat,
  output pqrr_pkg::pqrr_cmd_t  cmd
);
  import pqrr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PUSH_RES = 6'b000010,
    S_RD       = 6'b000100,
    S_PKT      = 6'b001000,
    S_ROW      = 6'b010000,
    S_EMPTY    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_take, out_take;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_cmd == OP_PUSH) begin
            cmd.push_exec = 1'b1;
            state_nxt     = S_PUSH_RES;
          end else begin
            cmd.drain_start = 1'b1;
            if (!stat.plan_pops_zero) begin
              state_nxt = S_RD;
            end else if (stat.plan_recover) begin
              state_nxt = S_ROW;
            end else begin
              state_nxt = S_EMPTY;
            end
          end
        end
      end
      S_PUSH_RES, S_EMPTY: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_PKT;
      end
      S_PKT: begin
        out_valid   = 1'b1;
        cmd.sel_mem = 1'b1;
        out_last    = stat.pops_zero && !stat.recov;
        if (out_take) begin
          if (!stat.pops_zero) begin
            state_nxt = S_RD;
          end else if (stat.recov) begin
            state_nxt = S_ROW;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ROW: begin
        out_valid   = 1'b1;
        cmd.sel_row = 1'b1;
        out_last    = stat.row_last;
        if (out_take) begin
          cmd.row_step = 1'b1;
          if (stat.row_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/pqrr_dp.sv
// ----------------------------------------------------------------------------
// pqrr_dp
// fifo store, pointers, row snapshots, status counters and result payload
// ----------------------------------------------------------------------------
module pqrr_dp #(
  parameter int FIFO_DEPTH  = pqrr_pkg::FIFO_DEPTH_DEF,
  parameter int ROW_COUNT   = pqrr_pkg::ROW_COUNT_DEF,
  parameter int DRAIN_BATCH = pqrr_pkg::DRAIN_BATCH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pqrr_pkg::pqrr_cmd_t         cmd,
  output pqrr_pkg::pqrr_stat_t        stat,
  input  logic [pqrr_pkg::BYTE_W-1:0] first_row,
  input  logic [pqrr_pkg::BYTE_W-1:0] in_command_byte,
  input  logic [pqrr_pkg::BYTE_W-1:0] in_argument_byte,
  input  logic [pqrr_pkg::BYTE_W-1:0] in_max_packets,
  output logic                        out_packet_valid,
  output logic [pqrr_pkg::BYTE_W-1:0] out_packet_command,
  output logic [pqrr_pkg::BYTE_W-1:0] out_packet_argument,
  output logic                        out_accepted,
  output logic [pqrr_pkg::PEND_W-1:0] out_pending_count,
  output logic [pqrr_pkg::STAT_W-1:0] out_overflow_count,
  output logic [pqrr_pkg::STAT_W-1:0] out_rejected_count,
  output logic [pqrr_pkg::STAT_W-1:0] out_dropped_pulse_count,
  output logic [pqrr_pkg::STAT_W-1:0] out_coalesced_row_count,
  output logic [pqrr_pkg::STAT_W-1:0] out_recovered_row_count,
  output logic                        out_recovery_pending
);
  import pqrr_pkg::*;

  localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int LIM_W  = $clog2(DRAIN_BATCH + 1);
  localparam int ROW_IW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int CMP_W  = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;
  localparam int ENT_W  = 2 * BYTE_W;

  localparam logic [STAT_W-1:0] STAT_MAX  = '1;
  localparam logic [STAT_W-1:0] ROW_ADD   = STAT_W'(ROW_COUNT);
  localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(FIFO_DEPTH);
  localparam logic [CMP_W-1:0]  BATCH_C   = CMP_W'(DRAIN_BATCH);
  localparam logic [CMP_W-1:0]  ROWS_C    = CMP_W'(ROW_COUNT);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [ROW_IW-1:0] ROW_LAST  = ROW_IW'(ROW_COUNT - 1);

  // fifo store
  logic [ENT_W-1:0] mem [FIFO_DEPTH];
  logic [ENT_W-1:0] mem_q_r;

  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  fill_r;
  logic [BYTE_W-1:0] snap_r [ROW_COUNT];
  logic              flag_r;
  logic [STAT_W-1:0] ovf_r, rej_r, drop_r, coal_r, recd_r;
  logic [LIM_W-1:0]  pops_r;
  logic              recov_r;
  logic [ROW_IW-1:0] row_idx_r;
  logic              acc_r;

  // row command decode
  logic [BYTE_W:0]   row_diff;
  logic              is_row;
  logic [ROW_IW-1:0] row_sel;
  logic              full;
  logic              push_ok;

  assign row_diff = {1'b0, in_command_byte} - {1'b0, first_row};
  assign is_row   = !row_diff[BYTE_W] && (row_diff[BYTE_W-1:0] < BYTE_W'(ROW_COUNT));
  assign row_sel  = row_diff[ROW_IW-1:0];
  assign full     = (CMP_W'(fill_r) >= DEPTH_C);
  assign push_ok  = cmd.push_exec && !flag_r && !full;

  // drain plan: packets to pop and whether the row replay follows
  logic [CMP_W-1:0] req_c, lim_c, fill_c, pop_c, rest_c;
  logic             plan_recover;

  assign req_c        = CMP_W'(in_max_packets);
  assign lim_c        = (req_c < BATCH_C) ? req_c : BATCH_C;
  assign fill_c       = CMP_W'(fill_r);
  assign pop_c        = (fill_c < lim_c) ? fill_c : lim_c;
  assign rest_c       = lim_c - pop_c;
  assign plan_recover = flag_r && (fill_c == pop_c) && (rest_c >= ROWS_C);

  assign stat.pops_zero      = (pops_r == '0);
  assign stat.recov          = recov_r;
  assign stat.row_last       = (row_idx_r == ROW_LAST);
  assign stat.plan_pops_zero = (pop_c == '0);
  assign stat.plan_recover   = plan_recover;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= {in_command_byte, in_argument_byte};
    end
    if (cmd.rd_issue) begin
      mem_q_r <= mem[rd_ptr_r];
    end
  end

  // control, pointers, snapshots and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      flag_r    <= 1'b0;
      ovf_r     <= '0;
      rej_r     <= '0;
      drop_r    <= '0;
      coal_r    <= '0;
      recd_r    <= '0;
      pops_r    <= '0;
      recov_r   <= 1'b0;
      row_idx_r <= '0;
      acc_r     <= 1'b0;
      for (int i = 0; i < ROW_COUNT; i++) begin
        snap_r[i] <= '0;
      end
    end else begin
      // push handling
      if (cmd.push_exec) begin
        acc_r <= push_ok;
        if (is_row) begin
          snap_r[row_sel] <= in_argument_byte;
        end
        if (flag_r) begin
          rej_r <= (rej_r == STAT_MAX) ? rej_r : rej_r + 1'b1;
          if (is_row) begin
            coal_r <= (coal_r == STAT_MAX) ? coal_r : coal_r + 1'b1;
          end else begin
            drop_r <= (drop_r == STAT_MAX) ? drop_r : drop_r + 1'b1;
          end
        end else if (full) begin
          ovf_r <= (ovf_r == STAT_MAX) ? ovf_r : ovf_r + 1'b1;
          rej_r <= (rej_r == STAT_MAX) ? rej_r : rej_r + 1'b1;
          if (is_row) begin
            flag_r <= 1'b1;
          end else begin
            drop_r <= (drop_r == STAT_MAX) ? drop_r : drop_r + 1'b1;
          end
        end else begin
          wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
          fill_r   <= fill_r + 1'b1;
        end
      end
      // drain start: status shows the post-drain state right away
      if (cmd.drain_start) begin
        acc_r     <= 1'b0;
        fill_r    <= CNT_W'(fill_c - pop_c);
        pops_r    <= LIM_W'(pop_c);
        recov_r   <= plan_recover;
        row_idx_r <= '0;
        if (plan_recover) begin
          flag_r <= 1'b0;
          recd_r <= (recd_r > STAT_MAX - ROW_ADD) ? STAT_MAX : recd_r + ROW_ADD;
        end
      end
      // one fifo pop
      if (cmd.rd_issue) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
        pops_r   <= pops_r - 1'b1;
      end
      // one row replayed
      if (cmd.row_step) begin
        row_idx_r <= row_idx_r + 1'b1;
      end
    end
  end

  // result payload
  always_comb begin
    out_packet_valid    = cmd.sel_mem || cmd.sel_row;
    out_packet_command  = '0;
    out_packet_argument = '0;
    if (cmd.sel_mem) begin
      out_packet_command  = mem_q_r[ENT_W-1:BYTE_W];
      out_packet_argument = mem_q_r[BYTE_W-1:0];
    end else if (cmd.sel_row) begin
      out_packet_command  = first_row + BYTE_W'(row_idx_r);
      out_packet_argument = snap_r[row_idx_r];
    end
  end

  assign out_accepted            = acc_r;
  assign out_pending_count       = PEND_W'(fill_r);
  assign out_overflow_count      = ovf_r;
  assign out_rejected_count      = rej_r;
  assign out_dropped_pulse_count = drop_r;
  assign out_coalesced_row_count = coal_r;
  assign out_recovered_row_count = recd_r;
  assign out_recovery_pending    = flag_r;

endmodule

>>> verif/panel_queue_with_row_recovery_unit_test.sv
// ----------------------------------------------------------------------------
// panel_queue_with_row_recovery_unit_test
// self-checking bench for the panel queue: random push/drain traffic with
// overflow and row replay episodes, checked result by result against a
// cycle-free prediction of the queue, over several first-row settings
// ----------------------------------------------------------------------------
module panel_queue_with_row_recovery_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pqrr_pkg::*;

  localparam int QUEUE_DEPTH    = FIFO_DEPTH_DEF;
  localparam int ROW_COUNT      = ROW_COUNT_DEF;
  localparam int DRAIN_BATCH    = DRAIN_BATCH_DEF;
  localparam int STALL_LIMIT    = 1000;
  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] command_byte;
    logic [BYTE_W-1:0] argument_byte;
    logic [BYTE_W-1:0] max_packets;
  } queue_request_t;

  typedef struct packed {
    logic              pkt_valid;
    logic [BYTE_W-1:0] pkt_cmd;
    logic [BYTE_W-1:0] pkt_arg;
    logic              last;
    logic              accepted;
    logic [PEND_W-1:0] pending;
    logic [STAT_W-1:0] overflow;
    logic [STAT_W-1:0] rejected;
    logic [STAT_W-1:0] dropped;
    logic [STAT_W-1:0] coalesced;
    logic [STAT_W-1:0] recovered;
    logic              recovering;
  } queue_result_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pqrr_in_if  req_ch ();
  pqrr_out_if res_ch ();

  panel_queue_with_row_recovery_unit #(
    .FIFO_DEPTH (QUEUE_DEPTH),
    .ROW_COUNT  (ROW_COUNT),
    .DRAIN_BATCH(DRAIN_BATCH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (req_ch),
    .out_ch     (res_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // bench state
  queue_request_t request_backlog[$];
  queue_result_t  predicted_results[$];
  queue_request_t drv_req;
  queue_result_t  want;
  int errors = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int in_gap_left = 0;
  int out_stall_left = 0;
  int quiet_cycles = 0;

  // shadow copy of the queue
  logic [2*BYTE_W-1:0] shadow_fifo[$];
  logic [BYTE_W-1:0]   shadow_rows[ROW_COUNT];
  logic                shadow_recovery = 1'b0;
  logic [BYTE_W-1:0]   shadow_first_row = FIRST_ROW_RST;
  logic [STAT_W-1:0]   shadow_overflow = '0;
  logic [STAT_W-1:0]   shadow_rejected = '0;
  logic [STAT_W-1:0]   shadow_dropped = '0;
  logic [STAT_W-1:0]   shadow_coalesced = '0;
  logic [STAT_W-1:0]   shadow_recovered = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [STAT_W-1:0] bump(logic [STAT_W-1:0] cnt, int n);
    logic [STAT_W:0] sum;
    sum = {1'b0, cnt} + n;
    return sum[STAT_W] ? STAT_MAX : sum[STAT_W-1:0];
  endfunction

  // work out the results of one accepted transaction
  function automatic void predict_queue_step(queue_request_t req);
    queue_result_t       batch[$];
    queue_result_t       r;
    logic [2*BYTE_W-1:0] entry;
    int                  row_idx;
    int                  limit;
    int                  popped;
    bit                  row_hit;
    row_idx = int'(req.command_byte) - int'(shadow_first_row);
    row_hit = (row_idx >= 0) && (row_idx < ROW_COUNT);
    r = '0;
    if (req.cmd == OP_PUSH) begin
      if (row_hit) shadow_rows[row_idx] = req.argument_byte;
      if (shadow_recovery) begin
        shadow_rejected = bump(shadow_rejected, 1);
        if (row_hit) shadow_coalesced = bump(shadow_coalesced, 1);
        else shadow_dropped = bump(shadow_dropped, 1);
      end else if (shadow_fifo.size() >= QUEUE_DEPTH) begin
        shadow_overflow = bump(shadow_overflow, 1);
        shadow_rejected = bump(shadow_rejected, 1);
        if (row_hit) shadow_recovery = 1'b1;
        else shadow_dropped = bump(shadow_dropped, 1);
      end else begin
        shadow_fifo.push_back({req.command_byte, req.argument_byte});
        r.accepted = 1'b1;
      end
      batch.push_back(r);
    end else begin
      limit = (req.max_packets < DRAIN_BATCH) ? int'(req.max_packets) : DRAIN_BATCH;
      popped = 0;
      while (popped < limit && shadow_fifo.size() > 0) begin
        entry = shadow_fifo.pop_front();
        r.pkt_valid = 1'b1;
        r.pkt_cmd = entry[2*BYTE_W-1:BYTE_W];
        r.pkt_arg = entry[BYTE_W-1:0];
        batch.push_back(r);
        popped++;
      end
      // row replay once the queue has run dry with room for all rows left in the batch
      if (shadow_recovery && shadow_fifo.size() == 0 && limit - popped >= ROW_COUNT) begin
        for (int k = 0; k < ROW_COUNT; k++) begin
          r.pkt_valid = 1'b1;
          r.pkt_cmd = 8'(int'(shadow_first_row) + k);
          r.pkt_arg = shadow_rows[k];
          batch.push_back(r);
        end
        shadow_recovered = bump(shadow_recovered, ROW_COUNT);
        shadow_recovery = 1'b0;
      end
      if (batch.size() == 0) batch.push_back(r);
    end
    // status reflects the state after the whole transaction
    foreach (batch[i]) begin
      batch[i].last = (i == batch.size() - 1);
      batch[i].pending = PEND_W'(shadow_fifo.size());
      batch[i].overflow = shadow_overflow;
      batch[i].rejected = shadow_rejected;
      batch[i].dropped = shadow_dropped;
      batch[i].coalesced = shadow_coalesced;
      batch[i].recovered = shadow_recovered;
      batch[i].recovering = shadow_recovery;
      predicted_results.push_back(batch[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [STAT_W-1:0] exp_v,
                                      logic [STAT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_queue_step(drv_req);
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (in_gap_left == 0 && in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
          in_gap_left = $urandom_range(1, 12);
        if (in_gap_left > 0) begin
          in_gap_left--;
          req_ch.valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          drv_req = request_backlog.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.cmd <= drv_req.cmd;
          req_ch.command_byte <= drv_req.command_byte;
          req_ch.argument_byte <= drv_req.argument_byte;
          req_ch.max_packets <= drv_req.max_packets;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cmd %0h arg %0h last %0b",
                   $time, res_ch.packet_command, res_ch.packet_argument, res_ch.last);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          check_field("packet_valid", want.pkt_valid, res_ch.packet_valid);
          check_field("packet_command", want.pkt_cmd, res_ch.packet_command);
          check_field("packet_argument", want.pkt_arg, res_ch.packet_argument);
          check_field("last", want.last, res_ch.last);
          check_field("accepted", want.accepted, res_ch.accepted);
          check_field("pending_count", want.pending, res_ch.pending_count);
          check_field("overflow_count", want.overflow, res_ch.overflow_count);
          check_field("rejected_count", want.rejected, res_ch.rejected_count);
          check_field("dropped_pulse_count", want.dropped, res_ch.dropped_pulse_count);
          check_field("coalesced_row_count", want.coalesced, res_ch.coalesced_row_count);
          check_field("recovered_row_count", want.recovered, res_ch.recovered_row_count);
          check_field("recovery_pending", want.recovering, res_ch.recovery_pending);
        end
      end
      if (out_stall_left == 0 && out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct)
        out_stall_left = $urandom_range(1, 12);
      if (out_stall_left > 0) begin
        out_stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_push(logic [BYTE_W-1:0] command_byte, logic [BYTE_W-1:0] argument_byte);
    request_backlog.push_back('{OP_PUSH, command_byte, argument_byte,
                                BYTE_W'($urandom_range(0, 255))});
  endtask

  task automatic add_drain(logic [BYTE_W-1:0] max_packets);
    request_backlog.push_back('{OP_DRAIN, BYTE_W'($urandom_range(0, 255)),
                                BYTE_W'($urandom_range(0, 255)), max_packets});
  endtask

  // mostly row commands of the current setting, some just outside the range
  function automatic logic [BYTE_W-1:0] pick_command();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return BYTE_W'(int'(shadow_first_row) + $urandom_range(0, ROW_COUNT - 1));
    if (sel < 60) return sel[0] ? BYTE_W'(int'(shadow_first_row) - 1)
                                : BYTE_W'(int'(shadow_first_row) + ROW_COUNT);
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_drain_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return BYTE_W'($urandom_range(DRAIN_BATCH, 255));
    if (sel < 90) return BYTE_W'($urandom_range(ROW_COUNT, DRAIN_BATCH - 1));
    return BYTE_W'($urandom_range(0, ROW_COUNT - 1));
  endfunction

  // fill-to-overflow episodes followed by drains, mixed with loose traffic
  task automatic queue_traffic(int budget);
    int  made;
    int  n;
    int  k;
    bit  fill_first;
    made = 0;
    fill_first = 1'b1;
    while (made < budget) begin
      if (fill_first || $urandom_range(0, 99) < 60) begin
        n = $urandom_range(54, 72);
        repeat (n) add_push(pick_command(), BYTE_W'($urandom_range(0, 255)));
        k = $urandom_range(5, 8);
        repeat (k) add_drain(pick_drain_size());
        made += n + k;
      end else begin
        n = $urandom_range(10, 20);
        repeat (n) begin
          if ($urandom_range(0, 99) < 65)
            add_push(pick_command(), BYTE_W'($urandom_range(0, 255)));
          else
            add_drain(BYTE_W'($urandom_range(0, 255)));
        end
        made += n;
      end
      fill_first = 1'b0;
    end
  endtask

  task automatic set_pacing();
    int pick;
    pick = $urandom_range(0, 2);
    in_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 20;
    pick = $urandom_range(0, 2);
    out_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 20;
  endtask

  // settle on a falling edge so every update of the cycle has landed
  task automatic wait_drained();
    do @(negedge clk);
    while (request_backlog.size() != 0 || req_ch.valid || predicted_results.size() != 0);
  endtask

  // register write or read-back through the config port
  task automatic cfg_access(bit wr, logic [BYTE_W-1:0] value);
    logic [CFG_DW-1:0] got;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= REG_FIRST_ROW;
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (wr) begin
      shadow_first_row = value;
    end else if (got !== CFG_DW'(value)) begin
      $display("%0t: first_row_command read mismatch, expected %0h, actual %0h",
               $time, value, got);
      errors++;
    end
  endtask

  // main sequence
  initial begin
    int row_bases[5];
    logic [BYTE_W-1:0] base;
    row_bases = '{0, 255, 250, 251, -1};
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd = OP_PUSH;
    req_ch.command_byte = '0;
    req_ch.argument_byte = '0;
    req_ch.max_packets = '0;
    res_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    foreach (shadow_rows[i]) shadow_rows[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    cfg_access(1'b0, FIRST_ROW_RST);

    // directed: empty drains, field extremes, row range edges, zero-size drain
    set_pacing();
    add_drain(8'd0);
    add_drain(8'd255);
    add_push(8'd0, 8'd0);
    add_push(8'd255, 8'd255);
    add_push(FIRST_ROW_RST, 8'hA5);
    add_push(BYTE_W'(FIRST_ROW_RST + ROW_COUNT - 1), 8'h5A);
    add_push(BYTE_W'(FIRST_ROW_RST + ROW_COUNT), 8'h01);
    add_push(BYTE_W'(FIRST_ROW_RST - 1), 8'hFF);
    add_push(BYTE_W'(FIRST_ROW_RST + 2), 8'h0F);
    add_drain(8'd0);
    add_drain(8'd1);
    add_drain(8'd255);
    add_push(BYTE_W'(FIRST_ROW_RST + 1), 8'hC3);
    add_drain(8'd16);
    queue_traffic(60);
    wait_drained();

    // row base at both ends and next to the wrap point
    foreach (row_bases[i]) begin
      base = (row_bases[i] < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(row_bases[i]);
      cfg_access(1'b1, base);
      cfg_access(1'b0, base);
      set_pacing();
      queue_traffic(60);
      wait_drained();
    end

    // closing stretch without idling on either side
    in_gap_pct = 0;
    out_stall_pct = 0;
    in_gap_left = 0;
    out_stall_left = 0;
    cfg_access(1'b1, FIRST_ROW_RST);
    cfg_access(1'b0, FIRST_ROW_RST);
    queue_traffic(60);
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
